### hw/rtl/websocket_frame_unmasker_assert.svh
// Assertion macros for the frame unmasker.
// Included by the RTL files that carry checks; empty when SYNTH is defined.
`ifndef WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH

`ifndef SYNTH
// Property checked on every edge outside reset
`define WSU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wsu assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define WSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsu sequence assertion failed");
`else
`define WSU_ASSERT(lbl, clk, rst, prop)
`define WSU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/wsu_pkg.sv
// Shared types and constants of the frame unmasker.
// No dependencies; used by the stream interfaces and the top level.
package wsu_pkg;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TOTAL_W = 18;

  // Header slack allowed on top of the client buffer size
  localparam logic [6:0] HEADER_SLACK = 7'd16;

  // Length field decode
  localparam logic [6:0] LEN_FIELD_MASK = 7'o177;
  localparam logic [6:0] LEN_EXTENDED   = 7'd126;

  // Header sizes: first byte, length byte, four key bytes (+2 extended)
  localparam logic [3:0] HLEN_BASIC = 4'd6;
  localparam logic [3:0] HLEN_EXT   = 4'd8;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [LEN_W-1:0]   MAX_PAYLOAD_RESET = {LEN_W{1'b1}};

  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_LEN     = 4'd1,
    PH_EXT_HI  = 4'd2,
    PH_EXT_LO  = 4'd3,
    PH_KEY0    = 4'd4,
    PH_KEY1    = 4'd5,
    PH_KEY2    = 4'd6,
    PH_KEY3    = 4'd7,
    PH_PAYLOAD = 4'd8
  } phase_t;

endpackage

### hw/rtl/wsu_stream_if.sv
// Valid/ready stream interfaces for received bytes and unmasked results.
// Depends on wsu_pkg for the length width.
interface wsu_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_read;

  modport source (output valid, rx_byte, end_of_read, input ready);
  modport sink   (input valid, rx_byte, end_of_read, output ready);
endinterface

interface wsu_tx_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               data_out;
  logic                     data_valid;
  logic                     last;
  logic                     status;
  logic [wsu_pkg::LEN_W-1:0] payload_length;

  modport source (output valid, data_out, data_valid, last, status, payload_length,
                  input ready);
  modport sink   (input valid, data_out, data_valid, last, status, payload_length,
                  output ready);
endinterface

### hw/rtl/websocket_frame_unmasker.sv
// Top level of the frame unmasker: header parse, key capture, payload XOR.
// Depends on wsu_pkg, wsu_stream_if.sv and websocket_frame_unmasker_assert.svh.
//
// Usage:
//   rx carries the received message one byte a beat, end_of_read set on the
//   final byte. tx carries one result beat for every payload byte and one for
//   the final byte; header bytes give no beat. On the final beat last is set,
//   status flags a length mismatch or an oversize message and payload_length
//   holds the decoded length. Payload bytes leave as they arrive, so the
//   consumer drops them if the final status is an error.
//   cfg_we/cfg_wdata write max_payload (reset 65535); write it only when idle.
// Timing:
//   One byte per cycle sustained while tx does not stall; a result appears
//   in the cycle after its byte is taken, held in the single output
//   register. rx.ready is high while that register is empty or being
//   drained, so a tx stall holds rx off until the pending beat is taken.
// Reset:
//   rst (synchronous) returns the parser to the first byte of a message and
//   empties the output register. After each final byte the parser clears
//   itself and the next byte opens a new message.
`include "websocket_frame_unmasker_assert.svh"

module websocket_frame_unmasker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [wsu_pkg::LEN_W-1:0] cfg_wdata,
  wsu_rx_if.sink                    rx,
  wsu_tx_if.source                  tx
);

  // Message state
  wsu_pkg::phase_t                phase, phase_next;
  logic [wsu_pkg::LEN_W-1:0]      length_reg, length_reg_next;
  logic [31:0]                    mask_key, mask_key_next;
  logic [wsu_pkg::LEN_W-1:0]      payload_index, payload_index_next;
  logic [wsu_pkg::TOTAL_W-1:0]    total_bytes, total_bytes_next;
  logic                           ext_header, ext_header_next;
  logic [wsu_pkg::LEN_W-1:0]      max_payload;

  // Per-beat results
  logic                           rx_fire;
  logic                           emit;
  logic                           pay_valid;
  logic [7:0]                     pay_data;
  logic                           err;
  logic [wsu_pkg::TOTAL_W-1:0]    expected_total;
  logic [wsu_pkg::LEN_W:0]        size_limit;
  logic [7:0]                     key_byte;

  assign rx.ready = !tx.valid || tx.ready;
  assign rx_fire  = rx.valid && rx.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= wsu_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  // Next phase
  always_comb begin
    unique case (phase)
      wsu_pkg::PH_FIRST:  phase_next = wsu_pkg::PH_LEN;
      wsu_pkg::PH_LEN: begin
        if ((rx.rx_byte[6:0] & wsu_pkg::LEN_FIELD_MASK) == wsu_pkg::LEN_EXTENDED) begin
          phase_next = wsu_pkg::PH_EXT_HI;
        end else begin
          phase_next = wsu_pkg::PH_KEY0;
        end
      end
      wsu_pkg::PH_EXT_HI: phase_next = wsu_pkg::PH_EXT_LO;
      wsu_pkg::PH_EXT_LO: phase_next = wsu_pkg::PH_KEY0;
      wsu_pkg::PH_KEY0:   phase_next = wsu_pkg::PH_KEY1;
      wsu_pkg::PH_KEY1:   phase_next = wsu_pkg::PH_KEY2;
      wsu_pkg::PH_KEY2:   phase_next = wsu_pkg::PH_KEY3;
      wsu_pkg::PH_KEY3:   phase_next = wsu_pkg::PH_PAYLOAD;
      default:            phase_next = wsu_pkg::PH_PAYLOAD;
    endcase
  end

  // Header fields, key capture and payload unmasking
  assign key_byte = mask_key[{payload_index[1:0], 3'b000} +: 8];

  always_comb begin
    length_reg_next    = length_reg;
    mask_key_next      = mask_key;
    payload_index_next = payload_index;
    ext_header_next    = ext_header;
    pay_valid          = 1'b0;
    pay_data           = 8'h00;

    if (total_bytes != wsu_pkg::TOTAL_MAX) begin
      total_bytes_next = total_bytes + 1'b1;
    end else begin
      total_bytes_next = total_bytes;
    end

    unique case (phase)
      wsu_pkg::PH_FIRST: ;
      wsu_pkg::PH_LEN: begin
        length_reg_next = {9'd0, rx.rx_byte[6:0] & wsu_pkg::LEN_FIELD_MASK};
        if ((rx.rx_byte[6:0] & wsu_pkg::LEN_FIELD_MASK) == wsu_pkg::LEN_EXTENDED) begin
          ext_header_next = 1'b1;
        end
      end
      wsu_pkg::PH_EXT_HI: length_reg_next = {rx.rx_byte, 8'h00};
      wsu_pkg::PH_EXT_LO: length_reg_next = {length_reg[15:8], rx.rx_byte};
      wsu_pkg::PH_KEY0:   mask_key_next[7:0]   = rx.rx_byte;
      wsu_pkg::PH_KEY1:   mask_key_next[15:8]  = rx.rx_byte;
      wsu_pkg::PH_KEY2:   mask_key_next[23:16] = rx.rx_byte;
      wsu_pkg::PH_KEY3:   mask_key_next[31:24] = rx.rx_byte;
      default: begin
        if (payload_index < length_reg) begin
          pay_valid          = 1'b1;
          pay_data           = rx.rx_byte ^ key_byte;
          payload_index_next = payload_index + 1'b1;
        end
      end
    endcase
  end

  // Final-byte status: header must be complete, header + payload must match count, and stay in bounds
  assign expected_total = {2'b00, length_reg_next}
                        + {14'd0, (ext_header_next ? wsu_pkg::HLEN_EXT : wsu_pkg::HLEN_BASIC)};
  assign size_limit     = {1'b0, max_payload} + 17'(wsu_pkg::HEADER_SLACK);

  always_comb begin
    err = 1'b0;
    if (phase_next != wsu_pkg::PH_PAYLOAD) begin
      err = 1'b1;
    end else if (expected_total != total_bytes_next) begin
      err = 1'b1;
    end
    if (total_bytes_next > {1'b0, size_limit}) begin
      err = 1'b1;
    end
  end

  assign emit = pay_valid || rx.end_of_read;

  // Message state registers; a final byte clears them
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wsu_pkg::PH_FIRST;
      length_reg    <= '0;
      mask_key      <= '0;
      payload_index <= '0;
      total_bytes   <= '0;
      ext_header    <= 1'b0;
    end else if (rx_fire) begin
      if (rx.end_of_read) begin
        phase         <= wsu_pkg::PH_FIRST;
        length_reg    <= '0;
        mask_key      <= '0;
        payload_index <= '0;
        total_bytes   <= '0;
        ext_header    <= 1'b0;
      end else begin
        phase         <= phase_next;
        length_reg    <= length_reg_next;
        mask_key      <= mask_key_next;
        payload_index <= payload_index_next;
        total_bytes   <= total_bytes_next;
        ext_header    <= ext_header_next;
      end
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (rx_fire) begin
      tx.valid <= emit;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (rx_fire && emit) begin
      tx.data_out       <= pay_data;
      tx.data_valid     <= pay_valid;
      tx.last           <= rx.end_of_read;
      tx.status         <= rx.end_of_read && err;
      tx.payload_length <= rx.end_of_read ? length_reg_next : '0;
    end
  end

  // Checks
  `WSU_ASSERT(a_index_in_length, clk, rst, payload_index <= length_reg)
  `WSU_ASSERT(a_mid_beat_is_data, clk, rst, (tx.valid && !tx.last) |-> tx.data_valid)
  `WSU_ASSERT(a_mid_beat_no_status, clk, rst, (tx.valid && !tx.last) |-> (!tx.status && tx.payload_length == '0))
  `WSU_ASSERT_NEXT(a_final_clears, clk, rst, rx_fire && rx.end_of_read, phase == wsu_pkg::PH_FIRST && total_bytes == '0)
  `WSU_ASSERT_NEXT(a_stall_holds, clk, rst, tx.valid && !tx.ready, tx.valid && $stable(tx.data_out) && $stable(tx.last))

endmodule
